FILE: src/m2q_pkg.sv
// Shared types and constants of the rotation-matrix-to-quaternion core.
// No dependencies.
`timescale 1ns / 1ps

package m2q_pkg;

  typedef enum logic [1:0] {
    SLOT_W,
    SLOT_X,
    SLOT_Y,
    SLOT_Z
  } slot_e;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

endpackage

FILE: src/m2q_front.sv
// Front end: trace test, pivot choice, root argument and numerators.
// Depends on m2q_pkg.
`timescale 1ns / 1ps

module m2q_front #(
  parameter int W = 16
) (
  input  logic signed [W-1:0] m00_i,
  input  logic signed [W-1:0] m01_i,
  input  logic signed [W-1:0] m02_i,
  input  logic signed [W-1:0] m10_i,
  input  logic signed [W-1:0] m11_i,
  input  logic signed [W-1:0] m12_i,
  input  logic signed [W-1:0] m20_i,
  input  logic signed [W-1:0] m21_i,
  input  logic signed [W-1:0] m22_i,
  output logic [4*W+5:0]      item_o
);

  typedef struct packed {
    m2q_pkg::slot_e  piv;
    logic [W:0]      arg;
    logic [2:0][W:0] d;
  } item_t;

  localparam logic [W+2:0] ONE_FX = (W+3)'(1) << (W-2);

  logic signed [W+2:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [W+2:0] tr, mii, arg_raw;
  logic signed [W+2:0] n0, n1, n2;
  logic                sel1, sel2;
  item_t               item;

  assign e00 = {{3{m00_i[W-1]}}, m00_i};
  assign e01 = {{3{m01_i[W-1]}}, m01_i};
  assign e02 = {{3{m02_i[W-1]}}, m02_i};
  assign e10 = {{3{m10_i[W-1]}}, m10_i};
  assign e11 = {{3{m11_i[W-1]}}, m11_i};
  assign e12 = {{3{m12_i[W-1]}}, m12_i};
  assign e20 = {{3{m20_i[W-1]}}, m20_i};
  assign e21 = {{3{m21_i[W-1]}}, m21_i};
  assign e22 = {{3{m22_i[W-1]}}, m22_i};

  assign tr   = e00 + e11 + e22;
  assign sel1 = e11 > e00;
  assign mii  = sel1 ? e11 : e00;
  assign sel2 = e22 > mii;

  always_comb begin
    if (tr > 0) begin
      item.piv = m2q_pkg::SLOT_W;
      arg_raw  = tr + ONE_FX;
      n0       = e12 - e21;
      n1       = e20 - e02;
      n2       = e01 - e10;
    end else if (sel2) begin
      item.piv = m2q_pkg::SLOT_Z;
      arg_raw  = e22 - (e00 + e11) + ONE_FX;
      n0       = e01 - e10;
      n1       = e20 + e02;
      n2       = e21 + e12;
    end else if (sel1) begin
      item.piv = m2q_pkg::SLOT_Y;
      arg_raw  = e11 - (e22 + e00) + ONE_FX;
      n0       = e20 - e02;
      n1       = e10 + e01;
      n2       = e12 + e21;
    end else begin
      item.piv = m2q_pkg::SLOT_X;
      arg_raw  = e00 - (e11 + e22) + ONE_FX;
      n0       = e12 - e21;
      n1       = e01 + e10;
      n2       = e02 + e20;
    end
    item.arg  = arg_raw[W+2] ? '0 : arg_raw[W:0];
    item.d[0] = n0[W:0];
    item.d[1] = n1[W:0];
    item.d[2] = n2[W:0];
  end

  assign item_o = item;

endmodule

FILE: src/m2q_queue.sv
// Short item queue between front end and back end.
// Depends on m2q_pkg for its depth.
`timescale 1ns / 1ps

module m2q_queue #(
  parameter int ITEM_W = 70
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [ITEM_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              pop_valid_o,
  output logic [ITEM_W-1:0] pop_data_o
);

  logic [ITEM_W-1:0]           mem_q [m2q_pkg::QUEUE_DEPTH];
  logic [m2q_pkg::QUEUE_AW-1:0] wr_q, rd_q;
  logic [m2q_pkg::QUEUE_AW:0]   count_q;
  logic                         do_push, do_pop;

  assign full_o      = count_q == (m2q_pkg::QUEUE_AW+1)'(m2q_pkg::QUEUE_DEPTH);
  assign pop_valid_o = count_q != '0;
  assign pop_data_o  = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (m2q_pkg::QUEUE_AW+1)'(m2q_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

FILE: src/m2q_back.sv
// Back end: pipelined square root, three pipelined dividers, saturation.
// Depends on m2q_pkg.
`timescale 1ns / 1ps

module m2q_back #(
  parameter int W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4*W+5:0]     item_i,
  input  logic               item_valid_i,
  output logic               item_take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [W-1:0] quat_w_o,
  output logic signed [W-1:0] quat_x_o,
  output logic signed [W-1:0] quat_y_o,
  output logic signed [W-1:0] quat_z_o
);

  localparam int NQ = 2*W - 1;

  typedef struct packed {
    m2q_pkg::slot_e  piv;
    logic [W:0]      arg;
    logic [2:0][W:0] d;
  } item_t;

  typedef struct packed {
    logic [2*W-1:0]  n;
    logic [W+1:0]    rem;
    logic [W-1:0]    root;
    m2q_pkg::slot_e  piv;
    logic [2:0][W:0] d;
  } sq_t;

  typedef struct packed {
    logic [NQ-1:0] nsh;
    logic [W:0]    rem;
    logic [NQ-1:0] q;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]    ln;
    logic [W:0]     den;
    logic           zero;
    logic [W-1:0]   pv;
    m2q_pkg::slot_e piv;
  } dv_t;

  localparam logic [NQ-1:0] HALF = (NQ)'(1) << (W-1);
  localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

  function automatic sq_t sq_step(sq_t p);
    sq_t          r;
    logic [W+1:0] rs, trial;
    r     = p;
    rs    = {p.rem[W-1:0], p.n[2*W-1 -: 2]};
    trial = {p.root, 2'b01};
    r.n   = p.n << 2;
    if (rs >= trial) begin
      r.rem  = rs - trial;
      r.root = {p.root[W-2:0], 1'b1};
    end else begin
      r.rem  = rs;
      r.root = {p.root[W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t p);
    dv_t          r;
    logic [W+1:0] rs;
    logic [W+1:0] diff;
    r = p;
    for (int l = 0; l < 3; l++) begin
      rs          = {p.ln[l].rem, p.ln[l].nsh[NQ-1]};
      diff        = rs - {1'b0, p.den};
      r.ln[l].nsh = p.ln[l].nsh << 1;
      if (rs >= {1'b0, p.den}) begin
        r.ln[l].rem = diff[W:0];
        r.ln[l].q   = {p.ln[l].q[NQ-2:0], 1'b1};
      end else begin
        r.ln[l].rem = rs[W:0];
        r.ln[l].q   = {p.ln[l].q[NQ-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [W-1:0] sat(lane_t l, logic zero);
    logic [W-1:0] v;
    if (zero) v = '0;
    else if (l.neg) v = (l.q > HALF) ? MINV : W'(~l.q[W-1:0] + 1'b1);
    else v = (l.q >= HALF) ? MAXV : l.q[W-1:0];
    return v;
  endfunction

  item_t        item;
  logic         en;
  sq_t          sq_in;
  sq_t          sq_q [W];
  logic [W-1:0] sq_v_q;
  dv_t          setup;
  dv_t          dv_q [NQ];
  logic [NQ-1:0] dv_v_q;
  logic [W:0]   pvs;
  logic [W:0]   mag [3];
  logic [W-1:0] lres [3];
  logic [W-1:0] w_d, x_d, y_d, z_d;
  logic [W-1:0] w_q, x_q, y_q, z_q;
  logic         out_valid_q;

  assign item        = item_i;
  assign en          = !out_valid_q || !out_stall_i;
  assign item_take_o = en;

  always_comb begin
    sq_in      = '0;
    sq_in.n    = {1'b0, (2*W-1)'(item.arg) << (W-2)};
    sq_in.piv  = item.piv;
    sq_in.d    = item.d;
  end

  always_comb begin
    setup      = '0;
    setup.den  = {sq_q[W-1].root, 1'b0};
    setup.zero = sq_q[W-1].root == '0;
    setup.piv  = sq_q[W-1].piv;
    pvs        = ((W+1)'(sq_q[W-1].root) + 1'b1) >> 1;
    setup.pv   = pvs[W-1] ? MAXV : pvs[W-1:0];
    for (int l = 0; l < 3; l++) begin
      mag[l]          = sq_q[W-1].d[l][W] ? (~sq_q[W-1].d[l] + 1'b1) : sq_q[W-1].d[l];
      setup.ln[l].neg = sq_q[W-1].d[l][W];
      setup.ln[l].nsh = ((NQ)'(mag[l]) << (W-2)) + (NQ)'(sq_q[W-1].root);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= sq_step(sq_in);
      for (int s = 1; s < W; s++) sq_q[s] <= sq_step(sq_q[s-1]);
      dv_q[0] <= dv_step(setup);
      for (int t = 1; t < NQ; t++) dv_q[t] <= dv_step(dv_q[t-1]);
      w_q <= w_d;
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) lres[l] = sat(dv_q[NQ-1].ln[l], dv_q[NQ-1].zero);
    unique case (dv_q[NQ-1].piv)
      m2q_pkg::SLOT_W: begin
        w_d = dv_q[NQ-1].pv; x_d = lres[0]; y_d = lres[1]; z_d = lres[2];
      end
      m2q_pkg::SLOT_X: begin
        w_d = lres[0]; x_d = dv_q[NQ-1].pv; y_d = lres[1]; z_d = lres[2];
      end
      m2q_pkg::SLOT_Y: begin
        w_d = lres[0]; x_d = lres[1]; y_d = dv_q[NQ-1].pv; z_d = lres[2];
      end
      default: begin
        w_d = lres[0]; x_d = lres[1]; y_d = lres[2]; z_d = dv_q[NQ-1].pv;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q      <= '0;
      dv_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sq_v_q      <= {sq_v_q[W-2:0], item_valid_i};
      dv_v_q      <= {dv_v_q[NQ-2:0], sq_v_q[W-1]};
      out_valid_q <= dv_v_q[NQ-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign quat_w_o    = w_q;
  assign quat_x_o    = x_q;
  assign quat_y_o    = y_q;
  assign quat_z_o    = z_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(w_q) && $stable(z_q)))
    else $error("stalled result dropped or changed");

endmodule

FILE: src/matrix_to_quaternion_core.sv
// Rotation matrix to quaternion, signed Q2.(WORD_WIDTH-2) in and out.
// Throughput: one item per cycle while neither in_stall_o nor out_stall_i holds the flow;
// digit-recurrence root and dividers retire one bit per stage. Path: queue, then
// WORD_WIDTH root stages, 2*WORD_WIDTH-1 divider stages and the output register.
// Reset: asynchronous, active low; clears queue pointers, queue count and stage valids only.
`timescale 1ns / 1ps

module matrix_to_quaternion_core #(
  parameter int WORD_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [WORD_WIDTH-1:0] row0_col0_i,
  input  logic signed [WORD_WIDTH-1:0] row0_col1_i,
  input  logic signed [WORD_WIDTH-1:0] row0_col2_i,
  input  logic signed [WORD_WIDTH-1:0] row1_col0_i,
  input  logic signed [WORD_WIDTH-1:0] row1_col1_i,
  input  logic signed [WORD_WIDTH-1:0] row1_col2_i,
  input  logic signed [WORD_WIDTH-1:0] row2_col0_i,
  input  logic signed [WORD_WIDTH-1:0] row2_col1_i,
  input  logic signed [WORD_WIDTH-1:0] row2_col2_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_WIDTH-1:0] quat_w_o,
  output logic signed [WORD_WIDTH-1:0] quat_x_o,
  output logic signed [WORD_WIDTH-1:0] quat_y_o,
  output logic signed [WORD_WIDTH-1:0] quat_z_o
);

  localparam int ITEM_W = 4*WORD_WIDTH + 6;

  logic [ITEM_W-1:0] front_item, queue_item;
  logic              queue_full, queue_valid, back_take;

  m2q_front #(.W(WORD_WIDTH)) u_front (
    .m00_i  (row0_col0_i),
    .m01_i  (row0_col1_i),
    .m02_i  (row0_col2_i),
    .m10_i  (row1_col0_i),
    .m11_i  (row1_col1_i),
    .m12_i  (row1_col2_i),
    .m20_i  (row2_col0_i),
    .m21_i  (row2_col1_i),
    .m22_i  (row2_col2_i),
    .item_o (front_item)
  );

  m2q_queue #(.ITEM_W(ITEM_W)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_item),
    .full_o      (queue_full),
    .pop_i       (back_take),
    .pop_valid_o (queue_valid),
    .pop_data_o  (queue_item)
  );

  m2q_back #(.W(WORD_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (queue_item),
    .item_valid_i (queue_valid),
    .item_take_o  (back_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .quat_w_o     (quat_w_o),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o)
  );

  assign in_stall_o = queue_full;

endmodule

FILE: tb/testbench.sv
// Testbench for matrix_to_quaternion_core: streams matrices under random idling and stalls,
// predicts each quaternion in a scoreboard class and checks every result field by field.
// Depends on src/m2q_pkg.sv and src/matrix_to_quaternion_core.sv.
`timescale 1ns / 1ps

module testbench;

  localparam int W = 16;
  localparam int F = W - 2;
  localparam longint ONE = 64'sd1 <<< F;
  localparam longint QMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint QMIN = -(64'sd1 <<< (W - 1));
  localparam int LATENCY = 3 * W;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1450;

  typedef logic signed [W-1:0] word_t;
  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
  } quat_t;

  localparam word_t ONE_W = word_t'(ONE);

  class quat_scoreboard;
    quat_t pending[$];
    int errors;
    int checked;

    function longint sat(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
    endfunction

    function longint isqrt(longint n);
      longint res;
      longint b;
      res = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >>> 1) + b;
        end else begin
          res = res >>> 1;
        end
        b = b >>> 2;
      end
      return res;
    endfunction

    function longint root_fx(longint a);
      if (a < 0) a = 0;
      return isqrt(a <<< F);
    endfunction

    function longint div_round(longint d, longint r);
      longint mag;
      longint q;
      if (r == 0) return 0;
      mag = (d < 0) ? -d : d;
      q = ((mag <<< F) + r) / (2 * r);
      return sat((d < 0) ? -q : q);
    endfunction

    function void note_matrix(word_t mat[9]);
      longint m[3][3];
      longint res[4];
      longint tr;
      longint r;
      int i;
      int j;
      int k;
      quat_t q;
      for (int a = 0; a < 9; a++) m[a / 3][a % 3] = mat[a];
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
        r = root_fx(tr + ONE);
        res[0] = sat((r + 1) >>> 1);
        res[1] = div_round(m[1][2] - m[2][1], r);
        res[2] = div_round(m[2][0] - m[0][2], r);
        res[3] = div_round(m[0][1] - m[1][0], r);
      end else begin
        i = 0;
        if (m[1][1] > m[0][0]) i = 1;
        if (m[2][2] > m[i][i]) i = 2;
        j = (i + 1) % 3;
        k = (j + 1) % 3;
        r = root_fx(m[i][i] - (m[j][j] + m[k][k]) + ONE);
        res[1 + i] = sat((r + 1) >>> 1);
        res[0] = div_round(m[j][k] - m[k][j], r);
        res[1 + j] = div_round(m[i][j] + m[j][i], r);
        res[1 + k] = div_round(m[i][k] + m[k][i], r);
      end
      q.w = word_t'(res[m2q_pkg::SLOT_W]);
      q.x = word_t'(res[m2q_pkg::SLOT_X]);
      q.y = word_t'(res[m2q_pkg::SLOT_Y]);
      q.z = word_t'(res[m2q_pkg::SLOT_Z]);
      pending.push_back(q);
    endfunction

    function void check_quat(quat_t got);
      quat_t e;
      if (pending.size() == 0) begin
        $error("unexpected result w=%0d x=%0d y=%0d z=%0d", got.w, got.x, got.y, got.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.w !== e.w) begin $error("quat_w expected %0d got %0d", e.w, got.w); errors++; end
      if (got.x !== e.x) begin $error("quat_x expected %0d got %0d", e.x, got.x); errors++; end
      if (got.y !== e.y) begin $error("quat_y expected %0d got %0d", e.y, got.y); errors++; end
      if (got.z !== e.z) begin $error("quat_z expected %0d got %0d", e.z, got.z); errors++; end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  word_t mat_q[9];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  word_t quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  quat_scoreboard sb = new();
  int idle_cycles = 0;
  bit timed_out = 0;
  int n_sent = 0;

  initial for (int a = 0; a < 9; a++) mat_q[a] = '0;

  always #4 clk_i = ~clk_i;

  matrix_to_quaternion_core #(.WORD_WIDTH(W)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .row0_col0_i(mat_q[0]), .row0_col1_i(mat_q[1]), .row0_col2_i(mat_q[2]),
    .row1_col0_i(mat_q[3]), .row1_col1_i(mat_q[4]), .row1_col2_i(mat_q[5]),
    .row2_col0_i(mat_q[6]), .row2_col1_i(mat_q[7]), .row2_col2_i(mat_q[8]),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .quat_w_o(quat_w_o), .quat_x_o(quat_x_o), .quat_y_o(quat_y_o), .quat_z_o(quat_z_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_matrix(mat_q);
      if (out_valid_o && !out_stall_i)
        sb.check_quat(quat_t'{w: quat_w_o, x: quat_x_o, y: quat_y_o, z: quat_z_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (!in_valid_i && sb.pending.size() == 0)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", sb.pending.size());
      $display("testbench failed");
      $finish;
    end
  end

  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(1, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_matrix(input word_t mat[9]);
    in_valid_i <= 1'b1;
    for (int a = 0; a < 9; a++) mat_q[a] <= mat[a];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic go_idle(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic word_t near(input int v, input int spread);
    return word_t'(v + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic send_rotation();
    word_t m[9];
    int c;
    int s;
    int root;
    int sel;
    c = int'($signed($urandom_range(0, 32'(2 * ONE)))) - int'(ONE);
    root = int'($sqrt(real'(ONE * ONE - c * c)));
    s = $urandom_range(0, 1) ? root : -root;
    sel = $urandom_range(0, 5);
    for (int a = 0; a < 9; a++) m[a] = near(0, 40);
    case (sel % 3)
      0: begin m[0] = near(int'(ONE), 3); m[4] = near(c, 3); m[8] = near(c, 3);
         m[5] = near(-s, 3); m[7] = near(s, 3); end
      1: begin m[4] = near(int'(ONE), 3); m[0] = near(c, 3); m[8] = near(c, 3);
         m[2] = near(s, 3); m[6] = near(-s, 3); end
      default: begin m[8] = near(int'(ONE), 3); m[0] = near(c, 3); m[4] = near(c, 3);
         m[1] = near(-s, 3); m[3] = near(s, 3); end
    endcase
    if (sel >= 3) begin
      for (int a = 0; a < 9; a++) if (a % 4 != 0) m[a] = near(m[a], 2000);
    end
    send_matrix(m);
  endtask

  task automatic send_noise();
    word_t m[9];
    for (int a = 0; a < 9; a++) begin
      case ($urandom_range(0, 5))
        0: m[a] = word_t'(QMAX);
        1: m[a] = word_t'(QMIN);
        default: m[a] = word_t'($urandom());
      endcase
    end
    send_matrix(m);
  endtask

  initial begin
    word_t d[9];
    int burst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    d = '{default: 0}; d[0] = ONE_W; d[4] = ONE_W; d[8] = ONE_W; send_matrix(d);
    d = '{default: 0}; d[0] = ONE_W; d[4] = -ONE_W; d[8] = -ONE_W; send_matrix(d);
    d = '{default: 0}; d[0] = -ONE_W; d[4] = ONE_W; d[8] = -ONE_W; send_matrix(d);
    d = '{default: 0}; d[0] = -ONE_W; d[4] = -ONE_W; d[8] = ONE_W; send_matrix(d);
    d = '{default: 0}; send_matrix(d);
    d = '{default: 0}; d[0] = word_t'(QMIN); d[4] = word_t'(QMIN); d[8] = word_t'(QMIN);
    send_matrix(d);
    d = '{default: word_t'(QMAX)}; send_matrix(d);
    d = '{default: word_t'(QMIN)}; send_matrix(d);
    d = '{default: 0}; d[0] = -ONE_W; d[4] = -ONE_W; d[8] = -ONE_W; d[1] = word_t'(QMAX);
    send_matrix(d);
    d = '{default: 0}; d[0] = 5; d[4] = 5; d[8] = 5; send_matrix(d);
    d = '{default: 0}; d[0] = 1; d[4] = 0; d[8] = -1; d[5] = word_t'(QMAX);
    d[7] = word_t'(QMIN); send_matrix(d);
    d = '{default: word_t'(QMAX)}; d[0] = 0; d[4] = 0; d[8] = 0; send_matrix(d);
    d = '{default: word_t'(QMIN)}; d[0] = word_t'(QMAX); send_matrix(d);
    d = '{default: -1}; send_matrix(d);
    d = '{default: 0}; d[0] = -ONE_W; d[4] = -ONE_W; d[8] = ONE_W; d[1] = 100; d[3] = -100;
    send_matrix(d);

    while (n_sent < N_RANDOM + 15) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if ($urandom_range(0, 3) != 0) send_rotation();
        else send_noise();
      end
      case ($urandom_range(0, 3))
        0: ;
        1: go_idle($urandom_range(1, 3));
        2: go_idle($urandom_range(1, 20));
        default: go_idle($urandom_range(LATENCY - 5, LATENCY + 10));
      endcase
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d matrices (rotations near each pivot axis, saturating and degenerate)",
             n_sent);
    $display("checked %0d quaternions with random input gaps and output stalls", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
src/m2q_pkg.sv
src/m2q_front.sv
src/m2q_queue.sv
src/m2q_back.sv
src/matrix_to_quaternion_core.sv
tb/testbench.sv
